// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the circle_point_generator top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMPL(lbl, clk_i, rstn_i, ante, cons) \
    lbl: assert property (@(posedge clk_i) disable iff (!(rstn_i)) (ante) |-> (cons)) \
        else $error("implication check failed");
`define ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
    lbl: assert property (@(posedge clk_i) disable iff (!(rstn_i)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPL(lbl, clk_i, rstn_i, ante, cons)
`define ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons)
`endif

`endif

// ----- hw/rtl/cpg_pkg.sv -----
// shared codes and constants for the circle point generator
package cpg_pkg;

    typedef enum logic
    {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } op_t;

    localparam int POINTS      = 8;
    localparam int DEC_INIT    = 3;
    localparam int DEC_ADD_NEG = 6;
    localparam int DEC_ADD_POS = 10;

endpackage

// ----- hw/rtl/cpg_front.sv -----
// front end: takes start and step beats, runs the decision variable, queues point jobs
module cpg_front #(
    parameter int COORD_BITS  = 12,
    parameter int RADIUS_BITS = 10,
    parameter int IN_W        = 40,
    parameter int JOB_W       = 45
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // center_x, center_y, radius
    input  logic [0:0]       s_tuser,   // op
    output logic             push,
    output logic [JOB_W-1:0] push_data,
    input  logic             full
);
    import cpg_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int R   = RADIUS_BITS;
    localparam int D_W = RADIUS_BITS + 4;

    logic [R-1:0]          x_reg, x_next;
    logic [R-1:0]          y_reg, y_next;
    logic signed [D_W-1:0] dec_reg, dec_next;
    logic [C-1:0]          cx_reg, cx_next;
    logic [C-1:0]          cy_reg, cy_next;
    logic                  active_reg, active_next;

    logic                  take;
    logic                  is_start;
    logic [D_W-1:0]        x_ext;
    logic [D_W-1:0]        y_ext;
    logic [D_W-1:0]        r_ext;
    logic [R+1:0]          x_plus;
    logic [R+1:0]          y_lim;
    logic                  done;

    assign s_tready = !full;
    assign take     = s_tvalid && s_tready;
    assign is_start = (s_tuser[0] == OP_START);
    assign x_ext    = {{4{1'b0}}, x_reg};
    assign y_ext    = {{4{1'b0}}, y_reg};
    assign r_ext    = {{4{1'b0}}, s_tdata[2*C+R-1:2*C]};

    always_comb
    begin
        x_next      = x_reg;
        y_next      = y_reg;
        dec_next    = dec_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        active_next = active_reg;
        push        = 1'b0;
        if (take)
        begin
            if (is_start)
            begin
                cx_next     = s_tdata[C-1:0];
                cy_next     = s_tdata[2*C-1:C];
                x_next      = '0;
                y_next      = s_tdata[2*C+R-1:2*C];
                dec_next    = D_W'(DEC_INIT) - (r_ext << 1);
                active_next = 1'b1;
                push        = 1'b1;
            end
            else if (active_reg)
            begin
                if (dec_reg[D_W-1])
                begin
                    dec_next = dec_reg + (x_ext << 2) + D_W'(DEC_ADD_NEG);
                end
                else
                begin
                    dec_next = dec_reg + ((x_ext - y_ext) << 2) + D_W'(DEC_ADD_POS);
                    y_next   = y_reg - R'(1);
                end
                x_next = x_reg + R'(1);
                push   = 1'b1;
            end
        end

        // look one step ahead: circle ends when the next x passes the next y
        x_plus = {2'b00, x_next} + (R+2)'(1);
        y_lim  = {2'b00, y_next} - (dec_next[D_W-1] ? (R+2)'(0) : (R+2)'(1));
        done   = $signed(x_plus) > $signed(y_lim);
        if (push && done)
        begin
            active_next = 1'b0;
        end
    end

    assign push_data = {done, cy_next, cx_next, y_next, x_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg      <= '0;
            y_reg      <= '0;
            dec_reg    <= '0;
            cx_reg     <= '0;
            cy_reg     <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            x_reg      <= x_next;
            y_reg      <= y_next;
            dec_reg    <= dec_next;
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            active_reg <= active_next;
        end
    end

endmodule

// ----- hw/rtl/cpg_queue.sv -----
// two-entry job queue between front and back ends
module cpg_queue #(
    parameter int W = 45
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output logic         full,
    output logic         empty
);
    logic [W-1:0] mem_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- hw/rtl/cpg_back.sv -----
// back end: walks the eight symmetric points of each job into the output register
module cpg_back #(
    parameter int COORD_BITS  = 12,
    parameter int RADIUS_BITS = 10,
    parameter int JOB_W       = 45,
    parameter int OUT_W       = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [JOB_W-1:0] q_data,
    input  logic             q_empty,
    output logic             q_pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // point_x, point_y
    output logic             m_tlast,   // last_of_step
    output logic [0:0]       m_tuser    // circle_done
);
    import cpg_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int R   = RADIUS_BITS;
    localparam int S_W = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2;

    logic [JOB_W-1:0] job_reg, job_next;
    logic             job_valid_reg, job_valid_next;
    logic [2:0]       idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] out_data_reg, out_data_next;
    logic             out_last_reg, out_last_next;
    logic             out_done_reg, out_done_next;

    logic [R-1:0]     jx, jy;
    logic [C-1:0]     jcx, jcy;
    logic             jdone;
    logic             advance, issue, last_pt;
    logic [R-1:0]     a_off, b_off;
    logic [S_W-1:0]   cx_s, cy_s, a_s, b_s, px, py;

    assign {jdone, jcy, jcx, jy, jx} = job_reg;

    assign advance = !out_valid_reg || m_tready;
    assign issue   = advance && job_valid_reg;
    assign last_pt = (idx_reg == 3'(POINTS - 1));
    assign q_pop   = !q_empty && (!job_valid_reg || (issue && last_pt));

    always_comb
    begin
        // first four points use (x, y), the rest swap them
        a_off = idx_reg[2] ? jy : jx;
        b_off = idx_reg[2] ? jx : jy;
        cx_s  = {{(S_W-C){jcx[C-1]}}, jcx};
        cy_s  = {{(S_W-C){jcy[C-1]}}, jcy};
        a_s   = {{(S_W-R){1'b0}}, a_off};
        b_s   = {{(S_W-R){1'b0}}, b_off};
        px    = idx_reg[0] ? (cx_s - a_s) : (cx_s + a_s);
        py    = idx_reg[1] ? (cy_s + b_s) : (cy_s - b_s);

        job_next       = job_reg;
        job_valid_next = job_valid_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_done_next  = out_done_reg;

        if (advance)
        begin
            out_valid_next = job_valid_reg;
            out_data_next  = OUT_W'({py[C:0], px[C:0]});
            out_last_next  = last_pt;
            out_done_next  = jdone;
        end
        if (issue)
        begin
            idx_next = idx_reg + 3'd1;
            if (last_pt)
            begin
                job_valid_next = 1'b0;
            end
        end
        if (q_pop)
        begin
            job_next       = q_data;
            job_valid_next = 1'b1;
            idx_next       = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_done_reg <= out_done_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tlast    = out_last_reg;
    assign m_tuser[0] = out_done_reg;

endmodule

// ----- hw/rtl/circle_point_generator.sv -----
// midpoint circle rasterizer: start/step beats in, eight symmetric points out per start or active step
// a taken beat's job passes through the queue and the back end's job register before
// its first point reaches the output register; the back end's single point path emits
// each item's points in turn, stalling while m_tready is low; a step taken while idle
// emits nothing; the two-entry queue lets the front take beats while the back emits
// reset: asynchronous active low; clears the queue, output register and circle state
`include "assert_macros.svh"

module circle_point_generator #(
    parameter int COORD_BITS  = 12,
    parameter int RADIUS_BITS = 10
) (
    input  logic                                                 clk,
    input  logic                                                 rst_n,
    input  logic                                                 s_tvalid,
    output logic                                                 s_tready,
    // center_x, center_y, radius
    input  logic [((2*COORD_BITS+RADIUS_BITS+7)/8)*8-1:0]         s_tdata,
    input  logic [0:0]                                           s_tuser,   // op
    output logic                                                 m_tvalid,
    input  logic                                                 m_tready,
    // point_x, point_y
    output logic [((2*(COORD_BITS+1)+7)/8)*8-1:0]                m_tdata,
    output logic                                                 m_tlast,   // last_of_step
    output logic [0:0]                                           m_tuser    // circle_done
);
    import cpg_pkg::*;

    localparam int IN_W  = ((2*COORD_BITS + RADIUS_BITS + 7) / 8) * 8;
    localparam int OUT_W = ((2*(COORD_BITS + 1) + 7) / 8) * 8;
    localparam int JOB_W = 2*COORD_BITS + 2*RADIUS_BITS + 1;

    logic             q_push;
    logic [JOB_W-1:0] q_push_data;
    logic             q_pop;
    logic [JOB_W-1:0] q_pop_data;
    logic             q_full;
    logic             q_empty;

    cpg_front #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS),
        .IN_W        (IN_W),
        .JOB_W       (JOB_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full)
    );

    cpg_queue #(
        .W (JOB_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    cpg_back #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS),
        .JOB_W       (JOB_W),
        .OUT_W       (OUT_W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_data   (q_pop_data),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // jobs never overrun or underrun the queue, and a pushed job is visible next cycle
    `ASSERT_IMPL(a_no_push_full, clk, rst_n, q_push, !q_full)
    `ASSERT_IMPL(a_no_pop_empty, clk, rst_n, q_pop, !q_empty)
    `ASSERT_NEXT(a_push_visible, clk, rst_n, q_push, !q_empty)

endmodule

// ----- test/tb_circle_point_generator.sv -----
// self-checking testbench for the midpoint circle point generator
module tb_circle_point_generator;

    import cpg_pkg::*;

    localparam int COORD_BITS  = 12;
    localparam int RADIUS_BITS = 10;
    localparam int IN_W        = ((2*COORD_BITS+RADIUS_BITS+7)/8)*8;
    localparam int OUT_W       = ((2*(COORD_BITS+1)+7)/8)*8;
    localparam int PT_W        = COORD_BITS + 1;
    localparam int CYCLE_LIMIT = 300000;
    localparam int N_RANDOM    = 400;

    // models the rasteriser and holds the points still owed by the block
    class circle_scoreboard;

        typedef struct {
            logic signed [PT_W-1:0] px;
            logic signed [PT_W-1:0] py;
            logic                   last;
            logic                   done;
        } point_t;

        point_t                         pending[$];
        logic [RADIUS_BITS-1:0]         ox;
        logic [RADIUS_BITS-1:0]         oy;
        logic signed [RADIUS_BITS+3:0]  dec;
        logic signed [COORD_BITS-1:0]   cx;
        logic signed [COORD_BITS-1:0]   cy;
        bit                             active;
        int                             errors;

        function new();
            ox     = '0;
            oy     = '0;
            dec    = '0;
            cx     = '0;
            cy     = '0;
            active = 1'b0;
            errors = 0;
        endfunction

        function void note_input(op_t op, logic signed [COORD_BITS-1:0] in_cx,
                                 logic signed [COORD_BITS-1:0] in_cy,
                                 logic [RADIUS_BITS-1:0] r);
            int     x;
            int     y;
            int     d;
            int     ny;
            int     a;
            int     b;
            int     sx;
            int     sy;
            bit     fin;
            point_t p;
            if (op == OP_START)
            begin
                cx     = in_cx;
                cy     = in_cy;
                ox     = '0;
                oy     = r;
                dec    = (RADIUS_BITS+4)'(DEC_INIT - 2 * int'(r));
                active = 1'b1;
            end
            else
            begin
                if (!active)
                    return;
                x = int'(ox);
                y = int'(oy);
                d = int'(dec);
                if (d < 0)
                    d += 4 * x + DEC_ADD_NEG;
                else
                begin
                    d += 4 * (x - y) + DEC_ADD_POS;
                    y--;
                end
                x++;
                ox  = RADIUS_BITS'(x);
                oy  = RADIUS_BITS'(y);
                dec = (RADIUS_BITS+4)'(d);
            end
            x   = int'(ox);
            y   = int'(oy);
            d   = int'(dec);
            // look one step ahead to see whether this item closes the circle
            ny  = (d < 0) ? y : y - 1;
            fin = (x + 1) > ny;
            for (int k = 0; k < POINTS; k++)
            begin
                a      = (k < 4) ? x : y;
                b      = (k < 4) ? y : x;
                sx     = (k % 2) ? -1 : 1;
                sy     = (k & 2) ? 1 : -1;
                p.px   = PT_W'(int'(cx) + sx * a);
                p.py   = PT_W'(int'(cy) + sy * b);
                p.last = (k == POINTS - 1);
                p.done = fin;
                pending.push_back(p);
            end
            if (fin)
                active = 1'b0;
        endfunction

        function void check_result(logic signed [PT_W-1:0] px, logic signed [PT_W-1:0] py,
                                   logic last, logic done);
            point_t p;
            if (pending.size() == 0)
            begin
                $error("unexpected point beat: point_x %0d point_y %0d", px, py);
                errors++;
                return;
            end
            p = pending.pop_front();
            if (px !== p.px)
            begin
                $error("point_x: expected %0d, actual %0d", p.px, px);
                errors++;
            end
            if (py !== p.py)
            begin
                $error("point_y: expected %0d, actual %0d", p.py, py);
                errors++;
            end
            if (last !== p.last)
            begin
                $error("last_of_step: expected %0b, actual %0b", p.last, last);
                errors++;
            end
            if (done !== p.done)
            begin
                $error("circle_done: expected %0b, actual %0b", p.done, done);
                errors++;
            end
        endfunction

    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;    // center_x, center_y, radius
    logic [0:0]       s_tuser;    // op
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;    // point_x, point_y
    logic             m_tlast;    // last_of_step
    logic [0:0]       m_tuser;    // circle_done

    int               src_idle_pct;
    int               snk_idle_pct;
    int               cycles = 0;
    int               n_counted;

    circle_scoreboard sb = new();

    circle_point_generator #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata[PT_W-1:0], m_tdata[2*PT_W-1:PT_W], m_tlast, m_tuser[0]);
    end

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_beat(input op_t op, input logic [IN_W-1:0] data);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        if (op == OP_START || sb.active)
            n_counted++;
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_input(op, data[COORD_BITS-1:0], data[2*COORD_BITS-1:COORD_BITS],
                      data[2*COORD_BITS+RADIUS_BITS-1:2*COORD_BITS]);
        @(negedge clk);
    endtask

    task automatic send_start(input logic [COORD_BITS-1:0] scx, input logic [COORD_BITS-1:0] scy,
                              input logic [RADIUS_BITS-1:0] r);
        logic [IN_W-1:0] data;
        data = '0;
        data[2*COORD_BITS+RADIUS_BITS-1:0] = {r, scy, scx};
        send_beat(OP_START, data);
    endtask

    // the fields are unused on a step, so they carry noise
    task automatic send_step();
        logic [IN_W-1:0] data;
        data = '0;
        data[2*COORD_BITS+RADIUS_BITS-1:0] =
            (2*COORD_BITS+RADIUS_BITS)'({$urandom(), $urandom()});
        send_beat(OP_STEP, data);
    endtask

    // hold the sender off until every owed point has come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending.size() != 0);
    endtask

    initial
    begin
        int kind;
        int cap;
        int steps;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = OP_START;
        n_counted    = 0;
        src_idle_pct = 25;
        snk_idle_pct = 48;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: idle steps, tiny radii, extreme centres and radius, abandon
        send_step();
        send_start(12'h800, 12'h7ff, 10'd0);
        send_step();
        send_start(12'h7ff, 12'h800, 10'd1);
        send_step();
        send_start(12'h7ff, 12'h7ff, 10'd1023);
        repeat (3) send_step();
        send_start(12'h800, 12'h800, 10'd1023);
        repeat (2) send_step();
        send_start(12'h000, 12'h000, 10'd5);
        while (sb.active)
            send_step();
        send_step();
        drain_results();

        n_counted = 0;
        while (n_counted < N_RANDOM)
        begin
            if (n_counted >= N_RANDOM / 3 && src_idle_pct == 25)
            begin
                drain_results();
                src_idle_pct = 48;
                snk_idle_pct = 25;
            end
            else if (n_counted >= 2 * N_RANDOM / 3 && src_idle_pct == 48)
            begin
                drain_results();
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            kind = $urandom_range(0, 9);
            if (kind == 0)
                send_step();
            else
            begin
                send_start(COORD_BITS'($urandom()), COORD_BITS'($urandom()),
                           RADIUS_BITS'((kind == 1) ? $urandom_range(0, 1023)
                                                    : $urandom_range(0, 24)));
                // large circles are cut short, some small ones too
                if (kind == 1)
                    cap = $urandom_range(1, 20);
                else if ($urandom_range(0, 7) == 0)
                    cap = $urandom_range(0, 6);
                else
                    cap = 1000;
                steps = 0;
                while (sb.active && steps < cap)
                begin
                    send_step();
                    steps++;
                end
            end
        end
        s_tvalid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (32) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- circle_point_generator.f -----
+incdir+hw/rtl
hw/rtl/cpg_pkg.sv
hw/rtl/cpg_front.sv
hw/rtl/cpg_queue.sv
hw/rtl/cpg_back.sv
hw/rtl/circle_point_generator.sv
test/tb_circle_point_generator.sv
